// ===== design/base64_stream_encoder_macros.svh =====
// ============================================================================
// base64_stream_encoder_macros.svh
// Assertion macros shared by the encoder's checker.
// ============================================================================
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// Same-cycle implication, masked while in reset.
`define B64E_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked while in reset.
`define B64E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define B64E_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/b64e_pkg.sv =====
// ============================================================================
// b64e_pkg
// Types, constants and the symbol-to-character map of the base64 encoder.
// ============================================================================
`default_nettype none

package b64e_pkg;

    // Depth of the job queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    // Position of the next byte within its 3-byte group.
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    localparam logic [6:0] PAD_CHAR   = 7'h3D;  // '='
    localparam logic [6:0] CHAR_UPPER = 7'h41;  // 'A'
    localparam logic [6:0] CHAR_LOWER = 7'h61;  // 'a'
    localparam logic [6:0] CHAR_DIGIT = 7'h30;  // '0'
    localparam logic [6:0] CHAR_PLUS  = 7'h2B;  // '+'
    localparam logic [6:0] CHAR_SLASH = 7'h2F;  // '/'

    // One classified byte: up to four characters to send.
    typedef struct packed {
        logic [3:0][6:0] chars;
        logic [1:0]      last_idx;   // index of the last character in chars
        logic            fin;        // last character ends the message
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } q_head_t;

    function automatic logic [6:0] sym_char(input logic [5:0] sym);
        logic [6:0] ch;
        if (sym < 6'd26)
            ch = CHAR_UPPER + 7'(sym);
        else if (sym < 6'd52)
            ch = CHAR_LOWER + 7'(sym - 6'd26);
        else if (sym < 6'd62)
            ch = CHAR_DIGIT + 7'(sym - 6'd52);
        else if (sym == 6'd62)
            ch = CHAR_PLUS;
        else
            ch = CHAR_SLASH;
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== design/b64e_front.sv =====
// ============================================================================
// b64e_front
// Accepts bytes, tracks group position and leftover bits, builds char jobs.
// ============================================================================
`default_nettype none

module b64e_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [7:0]   data_byte,
    input  wire logic         final_byte,
    input  wire logic         in_valid,
    input  wire logic         full,
    output logic              push,
    output b64e_pkg::job_t    push_job
);
    import b64e_pkg::*;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] left_reg, left_next;

    assign push = in_valid && !full;

    always_comb
    begin
        push_job          = '0;
        push_job.chars[2] = PAD_CHAR;
        push_job.chars[3] = PAD_CHAR;
        push_job.fin      = final_byte;
        phase_next        = phase_reg;
        left_next         = left_reg;
        unique case (phase_reg)
            PHASE_1:
            begin
                push_job.chars[0] = sym_char({left_reg[1:0], data_byte[7:4]});
                push_job.chars[1] = sym_char({data_byte[3:0], 2'b00});
                if (final_byte)
                begin
                    push_job.last_idx = 2'd2;
                    phase_next        = PHASE_0;
                    left_next         = '0;
                end
                else
                begin
                    push_job.last_idx = 2'd0;
                    phase_next        = PHASE_2;
                    left_next         = data_byte[3:0];
                end
            end
            PHASE_2:
            begin
                push_job.chars[0] = sym_char({left_reg, data_byte[7:6]});
                push_job.chars[1] = sym_char(data_byte[5:0]);
                push_job.last_idx = 2'd1;
                phase_next        = PHASE_0;
                left_next         = '0;
            end
            default:
            begin
                // unused code 3 behaves as the first byte of a group
                push_job.chars[0] = sym_char(data_byte[7:2]);
                push_job.chars[1] = sym_char({data_byte[1:0], 4'b0000});
                if (final_byte)
                begin
                    push_job.last_idx = 2'd3;
                    phase_next        = PHASE_0;
                    left_next         = '0;
                end
                else
                begin
                    push_job.last_idx = 2'd0;
                    phase_next        = PHASE_1;
                    left_next         = {2'b00, data_byte[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_0;
            left_reg  <= '0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/b64e_queue.sv =====
// ============================================================================
// b64e_queue
// Small FIFO of char jobs between front and back end.
// ============================================================================
`default_nettype none

module b64e_queue #(
    parameter int Depth = b64e_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire b64e_pkg::job_t  push_job,
    input  wire logic            pop,
    output b64e_pkg::q_head_t    head,
    output logic                 full
);
    import b64e_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    job_t            entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full       = (count_reg == CntW'(Depth));
    assign head.valid = (count_reg != '0);
    assign head.job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/b64e_back.sv =====
// ============================================================================
// b64e_back
// Walks the head job into the output register, one char per unstalled cycle.
// ============================================================================
`default_nettype none

module b64e_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire b64e_pkg::q_head_t head,
    output logic                   pop,
    output logic [6:0]             text_char,
    output logic                   final_char,
    output logic                   out_valid,
    input  wire logic              out_stall
);
    import b64e_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [6:0] char_reg;
    logic       fin_reg;
    logic       load;
    logic       at_last;

    assign load    = head.valid && (!valid_reg || !out_stall);
    assign at_last = (idx_reg == head.job.last_idx);
    assign pop     = load && at_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && out_stall;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = at_last ? 2'd0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= head.job.chars[idx_reg];
            fin_reg  <= head.job.fin && at_last;
        end
    end

    assign text_char  = char_reg;
    assign final_char = fin_reg;
    assign out_valid  = valid_reg;

endmodule

`default_nettype wire

// ===== design/base64_stream_encoder.sv =====
// ============================================================================
// base64_stream_encoder
// Byte stream to base64 text, standard alphabet with '=' padding.
// ============================================================================
//
//   channel  direction  payload                  handshake
//   -------  ---------  -----------------------  ---------------------
//   in       to block   data_byte, final_byte    in_valid / in_stall
//   out      from block text_char, final_char    out_valid / out_stall
//
// An item is taken at a clock edge with valid high and stall low.
// Each byte is turned into a job of 1 to 4 characters in the cycle it is
// taken; characters then leave at one per cycle from the output register
// while out_stall is low. A full 3-byte group gives 4 characters; a final
// byte adds any padding characters that its group needs.
// The front end takes a byte each cycle until the job queue (QueueDepth
// jobs) is full; in_stall is simply "queue full".
// Reset (rst_n low, asynchronous) empties the queue, drops any character
// in the output register and starts at the first byte of a group.
// A stalled output holds its character; the front accepts until queue full.
// ============================================================================
`default_nettype none

module base64_stream_encoder #(
    parameter int QueueDepth = b64e_pkg::QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] data_byte,
    input  wire logic       final_byte,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic [6:0]      text_char,
    output logic            final_char,
    output logic            out_valid,
    input  wire logic       out_stall
);
    import b64e_pkg::*;

    logic    push;
    logic    pop;
    logic    full;
    job_t    push_job;
    q_head_t head;

    // byte classification and group state
    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .in_valid   (in_valid),
        .full       (full),
        .push       (push),
        .push_job   (push_job)
    );

    // decouples input acceptance from output stalls
    b64e_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (full)
    );

    // character serialiser with registered output
    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .text_char  (text_char),
        .final_char (final_char),
        .out_valid  (out_valid),
        .out_stall  (out_stall)
    );

    assign in_stall = full;

endmodule

`default_nettype wire

// ===== design/b64e_checker.sv =====
// ============================================================================
// b64e_checker
// Port-level checks on the base64 encoder, bound to the top level.
// ============================================================================
`default_nettype none

`include "base64_stream_encoder_macros.svh"

module b64e_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] data_byte,
    input  wire logic       final_byte,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [6:0] text_char,
    input  wire logic       final_char,
    input  wire logic       out_valid,
    input  wire logic       out_stall
);
    import b64e_pkg::*;

    logic legal_char;
    logic in_wait;
    logic out_wait;
    logic first_pad;
    logic last_pad;

    assign in_wait   = in_valid && in_stall;
    assign out_wait  = out_valid && out_stall;
    assign first_pad = out_valid && !out_stall && text_char == PAD_CHAR && !final_char;
    assign last_pad  = out_valid && text_char == PAD_CHAR && final_char;

    assign legal_char =
        (text_char >= 7'h41 && text_char <= 7'h5A) ||
        (text_char >= 7'h61 && text_char <= 7'h7A) ||
        (text_char >= 7'h30 && text_char <= 7'h39) ||
        text_char == CHAR_PLUS || text_char == CHAR_SLASH || text_char == PAD_CHAR;

    // a stalled character holds
    `B64E_ASSERT_NEXT(a_hold, clk, rst_n, out_wait, out_valid && $stable({text_char, final_char}))

    // a stalled input item holds
    `B64E_ASSERT_NEXT(a_in_hold, clk, rst_n, in_wait, in_valid && $stable({data_byte, final_byte}))

    // only alphabet characters or padding leave the block
    `B64E_ASSERT_SAME(a_alphabet, clk, rst_n, out_valid, legal_char)

    // the first of two pads is followed at once by the final pad
    `B64E_ASSERT_NEXT(a_pad_pair, clk, rst_n, first_pad, last_pad)

    // nothing is offered while in reset
    `B64E_ASSERT_ALWAYS(a_reset, clk, !rst_n, !out_valid)

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .text_char  (text_char),
    .final_char (final_char),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
);

`default_nettype wire
